// ===== rtl/tdi_pkg.sv =====
// Shared types and constants for the timestamp domain interpolator.
package tdi_pkg;

    localparam int unsigned DEV_W   = 32;
    localparam int unsigned HOST_W  = 63;
    localparam int unsigned MAP_W   = 64;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned PROD_W  = HOST_W + DEV_W;
    localparam int unsigned CNT_W   = 7;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DEV_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);
    localparam logic signed [20:0] NS_PER_MS = 21'sd1000000;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd0;
    localparam logic [STAT_W-1:0] ST_SINGLE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_INTERP  = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZSPAN   = 3'd3;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd4;

    typedef struct packed {
        logic              op;
        logic [DEV_W-1:0]  device_time_ms;
        logic [HOST_W-1:0] host_time_ns;
    } t_req;

    typedef struct packed {
        logic [MAP_W-1:0]  mapped_time_ns;
        logic [STAT_W-1:0] map_status;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic rec;
        logic rd_first;
        logic rd_next;
        logic latch_prev;
        logic set_empty;
        logic single_mul;
        logic single_add;
        logic set_newest;
        logic set_zspan;
        logic mul_init;
        logic mul_step;
        logic div_step;
        logic finish;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic cnt_zero;
        logic cnt_one;
        logic bracket;
        logic span_zero;
        logic age_last;
    } t_sts;

endpackage

// ===== rtl/tdi_ctrl.sv =====
// Sequencer for record and query requests of the timestamp interpolator.
module tdi_ctrl import tdi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output logic o_stall,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_REC  = 4'd1;
    localparam logic [3:0] S_Q    = 4'd2;
    localparam logic [3:0] S_S1   = 4'd3;
    localparam logic [3:0] S_S1B  = 4'd4;
    localparam logic [3:0] S_P0   = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid && i_stall;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_Q;
                    if (i_sts.op == OP_RECORD) begin
                        n_state = S_REC;
                    end
                end
            end
            S_REC: begin
                o_cmd.rec = 1'b1;
                n_state = S_IDLE;
            end
            S_Q: begin
                if (i_sts.cnt_zero) begin
                    o_cmd.set_empty = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state = i_sts.cnt_one ? S_S1 : S_P0;
                end
            end
            S_S1: begin
                o_cmd.single_mul = 1'b1;
                n_state = S_S1B;
            end
            S_S1B: begin
                o_cmd.single_add = 1'b1;
                n_state = S_DONE;
            end
            S_P0: begin
                o_cmd.latch_prev = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.bracket) begin
                    if (i_sts.span_zero) begin
                        o_cmd.set_zspan = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.mul_init = 1'b1;
                        n_cnt = '0;
                        n_state = S_MUL;
                    end
                end else if (i_sts.age_last) begin
                    o_cmd.set_newest = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.latch_prev = 1'b1;
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_cnt = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== rtl/tdi_dp.sv =====
// Datapath of the timestamp interpolator: pair ring, scan, multiply and divide.
module tdi_dp import tdi_pkg::*; #(
    parameter int unsigned PAIR_DEPTH = 20
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_rsp o_rsp
);

    localparam int unsigned IW = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int unsigned CW = $clog2(PAIR_DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    logic [DEV_W-1:0]  mem_dev  [PAIR_DEPTH];
    logic [HOST_W-1:0] mem_host [PAIR_DEPTH];

    logic [IW-1:0]     r_oldest;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_age, n_age;
    logic [DEV_W-1:0]  r_qdev, r_rd_dev, r_prev_dev, r_dt;
    logic [HOST_W-1:0] r_qhost, r_rd_host, r_prev_host;
    logic signed [53:0] r_prod;
    logic [MAP_W-1:0]  r_res;
    logic [STAT_W-1:0] r_stat;
    logic              r_neg;
    logic [PROD_W-1:0] r_acc, r_mcand;
    logic [DEV_W-1:0]  r_mplier, r_rem;
    t_rsp              r_out;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] oldest,
                                              input logic [CW-1:0] age);
        logic [SW-1:0] s;
        s = SW'(oldest) + SW'(age);
        if (s >= SW'(PAIR_DEPTH)) begin
            s = s - SW'(PAIR_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    logic [IW-1:0]      rd_slot, wr_slot;
    logic signed [32:0] off_ms;
    logic [DEV_W:0]     div_t;
    logic               div_ge;
    logic [HOST_W-1:0]  mag;

    always_comb begin
        n_age   = i_cmd.rd_first ? '0 : r_age + 1'b1;
        rd_slot = slot_of(r_oldest, CW'(n_age));
        wr_slot = slot_of(r_oldest, r_count);
        off_ms  = $signed({1'b0, r_qdev}) - $signed({1'b0, r_rd_dev});
        div_t   = {r_rem, r_acc[PROD_W-1]};
        div_ge  = (div_t >= {1'b0, r_dt});
        mag     = (r_rd_host < r_prev_host) ? (r_prev_host - r_rd_host)
                                            : (r_rd_host - r_prev_host);
    end

    // pair ring storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.rec) begin
            mem_dev[wr_slot]  <= r_qdev;
            mem_host[wr_slot] <= r_qhost;
        end
        if (i_cmd.rd_first || i_cmd.rd_next) begin
            r_rd_dev  <= mem_dev[rd_slot];
            r_rd_host <= mem_host[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_count  <= '0;
        end else if (i_cmd.rec) begin
            if (r_count < CW'(PAIR_DEPTH)) begin
                r_count <= r_count + 1'b1;
            end else begin
                r_oldest <= slot_of(r_oldest, CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qdev  <= i_req.device_time_ms;
            r_qhost <= i_req.host_time_ns;
        end
        if (i_cmd.rd_first || i_cmd.rd_next) begin
            r_age <= n_age;
        end
        if (i_cmd.latch_prev) begin
            r_prev_dev  <= r_rd_dev;
            r_prev_host <= r_rd_host;
        end
        if (i_cmd.set_empty) begin
            r_res  <= '0;
            r_stat <= ST_EMPTY;
        end
        if (i_cmd.single_mul) begin
            r_prod <= off_ms * NS_PER_MS;
        end
        if (i_cmd.single_add) begin
            r_res  <= {1'b0, r_rd_host} + {{(MAP_W-54){r_prod[53]}}, r_prod};
            r_stat <= ST_SINGLE;
        end
        if (i_cmd.set_zspan) begin
            r_res  <= {1'b0, r_rd_host};
            r_stat <= ST_ZSPAN;
        end
        if (i_cmd.set_newest) begin
            r_res  <= {1'b0, r_rd_host};
            r_stat <= ST_OUTSIDE;
        end
        if (i_cmd.mul_init) begin
            r_neg    <= (r_rd_host < r_prev_host);
            r_mplier <= r_qdev - r_prev_dev;
            r_dt     <= r_rd_dev - r_prev_dev;
            r_acc    <= '0;
            r_rem    <= '0;
        end
        if (i_cmd.mul_init) begin
            r_mcand <= {DEV_W'(0), mag};
        end else if (i_cmd.mul_step) begin
            r_mcand <= {r_mcand[PROD_W-2:0], 1'b0};
        end
        if (i_cmd.mul_step) begin
            r_mplier <= {1'b0, r_mplier[DEV_W-1:1]};
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? DEV_W'(div_t - {1'b0, r_dt}) : div_t[DEV_W-1:0];
            r_acc <= {r_acc[PROD_W-2:0], div_ge};
        end
        if (i_cmd.finish) begin
            r_res  <= r_neg ? ({1'b0, r_prev_host} - r_acc[MAP_W-1:0])
                            : ({1'b0, r_prev_host} + r_acc[MAP_W-1:0]);
            r_stat <= ST_INTERP;
        end
        if (i_cmd.load_out) begin
            r_out.mapped_time_ns <= r_res;
            r_out.map_status     <= r_stat;
        end
    end

    always_comb begin
        o_sts.op        = i_req.op;
        o_sts.cnt_zero  = (r_count == '0);
        o_sts.cnt_one   = (r_count == CW'(1));
        o_sts.bracket   = (r_qdev >= r_prev_dev) && (r_qdev <= r_rd_dev);
        o_sts.span_zero = (r_rd_dev == r_prev_dev);
        o_sts.age_last  = ((CW'(r_age) + 1'b1) == r_count);
    end

    assign o_rsp = r_out;

endmodule

// ===== rtl/timestamp_domain_interpolator.sv =====
// Top level of the timestamp domain interpolator.
//
// Maps a device clock in milliseconds onto host time in nanoseconds from a
// ring of the newest PAIR_DEPTH recorded time pairs.
// Input channel i_valid / o_stall carries one request t_req: op 0 records a
// pair (no result), op 1 queries a device time (one result on o_rsp).
// Output channel o_valid / i_stall carries t_rsp, held in an output register.
// A request is taken only when the block is idle, so one request at a time.
// Interpolated query: a scan of the ring for the bracketing interval, one
// ring read a cycle on the single read port, then a shift-add multiply over
// the DEV_W multiplier bits, a restoring divide over the PROD_W product bits,
// one finishing add and one output load. A zero span or no bracketing
// interval ends the query after the scan.
// Reset (synchronous, active low) empties the ring; stored pairs are not
// cleared, they are simply not valid. While the receiver stalls, the result
// holds in the output register, the next request may still be taken, and
// that request's result waits in the datapath until the register frees.
module timestamp_domain_interpolator import tdi_pkg::*; #(
    parameter int unsigned PAIR_DEPTH = 20
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: steps each request through record, scan, multiply, divide
    tdi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // datapath: ring memory, bracket compare and arithmetic units
    tdi_dp #(
        .PAIR_DEPTH (PAIR_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule
